### design/fmvt_pkg.sv
// ----------------------------------------------------------------------------
// fmvt_pkg: shared types and constants for the Q16.16 4x4 transform unit
// Word layouts, operation codes and the stage-enable bundle used by the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package fmvt_pkg;

  localparam int unsigned Dim      = 4;
  localparam int unsigned Entries  = Dim * Dim;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned ElemW    = 32;
  localparam int unsigned AccW     = 64;
  localparam int unsigned FracBits = 16;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef enum logic {
    OpLoad      = 1'b0,
    OpTransform = 1'b1
  } op_e;

  typedef struct packed {
    op_e             operation;
    logic [IdxW-1:0] entry_index;
    elem_t           entry_value;
    elem_t           vec_x;
    elem_t           vec_y;
    elem_t           vec_z;
    elem_t           vec_w;
  } in_t;

  typedef struct packed {
    elem_t result_x;
    elem_t result_y;
    elem_t result_z;
    elem_t result_w;
  } out_t;

  // Load enables for the two register stages inside each lane.
  typedef struct packed {
    logic prod;
    logic pair;
  } stage_en_t;

endpackage

`default_nettype wire

### design/fmvt_lane.sv
// ----------------------------------------------------------------------------
// fmvt_lane: one output column of the transform
// Four signed 32x32 products are registered, summed in pairs, and the two
// pair sums are presented to the merge stage for the final add.
// ----------------------------------------------------------------------------
`default_nettype none

module fmvt_lane (
  input  wire logic                 clk_i,
  input  wire fmvt_pkg::stage_en_t  en_i,
  input  wire fmvt_pkg::elem_t      vec_i [fmvt_pkg::Dim],
  input  wire fmvt_pkg::elem_t      col_i [fmvt_pkg::Dim],
  output fmvt_pkg::acc_t            pair_o [2]
);

  fmvt_pkg::acc_t prod_d [fmvt_pkg::Dim];
  fmvt_pkg::acc_t prod_q [fmvt_pkg::Dim];
  fmvt_pkg::acc_t pair_d [2];
  fmvt_pkg::acc_t pair_q [2];

  // Both operands are signed 32-bit, so the 64-bit product is exact.
  always_comb begin
    for (int r = 0; r < fmvt_pkg::Dim; r++) begin
      prod_d[r] = fmvt_pkg::acc_t'(vec_i[r]) * fmvt_pkg::acc_t'(col_i[r]);
    end
  end

  // Column sums wrap modulo 2^64, which plain 64-bit adds give for free.
  assign pair_d[0] = prod_q[0] + prod_q[1];
  assign pair_d[1] = prod_q[2] + prod_q[3];

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
    if (en_i.pair) begin
      pair_q <= pair_d;
    end
  end

  assign pair_o = pair_q;

endmodule

`default_nettype wire

### design/fmvt_merge.sv
// ----------------------------------------------------------------------------
// fmvt_merge: final column add, fraction shift and output register
// Finishes each lane's sum, drops the fraction bits and packs the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module fmvt_merge (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire fmvt_pkg::acc_t  pair_i [fmvt_pkg::Dim][2],
  output fmvt_pkg::out_t       res_o
);

  fmvt_pkg::acc_t  sum   [fmvt_pkg::Dim];
  fmvt_pkg::elem_t comp  [fmvt_pkg::Dim];
  fmvt_pkg::out_t  res_d;
  fmvt_pkg::out_t  res_q;

  // An arithmetic shift followed by truncation to 32 bits is just a window
  // into the 64-bit sum starting at the binary point.
  always_comb begin
    for (int c = 0; c < fmvt_pkg::Dim; c++) begin
      sum[c]  = pair_i[c][0] + pair_i[c][1];
      comp[c] = sum[c][fmvt_pkg::FracBits +: fmvt_pkg::ElemW];
    end
    res_d.result_x = comp[0];
    res_d.result_y = comp[1];
    res_d.result_z = comp[2];
    res_d.result_w = comp[3];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### design/fixed_mat4_vector_transform.sv
// ----------------------------------------------------------------------------
// fixed_mat4_vector_transform: Q16.16 4x4 matrix times row vector
// Holds a 16-entry matrix; load words write one entry, transform words
// return out[c] = sum over r of v[r] * M[r][c], shifted down by 16 bits.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Word
//   --------+-----------+------------------------+----------------
//   input   | in        | in_valid_i / in_ready_o | fmvt_pkg::in_t
//   output  | out       | out_valid_o / out_ready_i | fmvt_pkg::out_t
//
// One word is accepted per cycle while in_ready_o is high. For a transform,
// the result passes the multiplier stage, the pair-add stage and the final
// add in the output register before out_valid_o rises. Loads take effect at
// acceptance and yield no result word, so a transform in the very next cycle
// already sees the new entry.
// Reset clears the matrix to zero and empties the pipeline.
// While the output is stalled the earlier stages keep filling; in_ready_o
// drops only when all three stages hold a word.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_mat4_vector_transform (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire fmvt_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output fmvt_pkg::out_t       out_data_o
);

  fmvt_pkg::elem_t   mat_q [fmvt_pkg::Entries];
  fmvt_pkg::elem_t   vec   [fmvt_pkg::Dim];
  fmvt_pkg::elem_t   col   [fmvt_pkg::Dim][fmvt_pkg::Dim];
  fmvt_pkg::acc_t    pair  [fmvt_pkg::Dim][2];
  fmvt_pkg::stage_en_t lane_en;

  logic prod_valid_q, pair_valid_q, out_valid_q;
  logic prod_rdy, pair_rdy, out_rdy;
  logic accept, load_acc, xfm_acc;

  // Each stage may load when it is empty or its contents move on.
  assign out_rdy  = !out_valid_q  || out_ready_i;
  assign pair_rdy = !pair_valid_q || out_rdy;
  assign prod_rdy = !prod_valid_q || pair_rdy;

  assign in_ready_o = prod_rdy;
  assign accept     = in_valid_i && prod_rdy;
  assign load_acc   = accept && (in_data_i.operation == fmvt_pkg::OpLoad);
  assign xfm_acc    = accept && (in_data_i.operation == fmvt_pkg::OpTransform);

  assign lane_en.prod = xfm_acc;
  assign lane_en.pair = pair_rdy && prod_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      pair_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (prod_rdy) begin
        prod_valid_q <= xfm_acc;
      end
      if (pair_rdy) begin
        pair_valid_q <= prod_valid_q;
      end
      if (out_rdy) begin
        out_valid_q <= pair_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fmvt_pkg::Entries; i++) begin
        mat_q[i] <= '0;
      end
    end else if (load_acc) begin
      mat_q[in_data_i.entry_index] <= in_data_i.entry_value;
    end
  end

  always_comb begin
    vec[0] = in_data_i.vec_x;
    vec[1] = in_data_i.vec_y;
    vec[2] = in_data_i.vec_z;
    vec[3] = in_data_i.vec_w;
    for (int c = 0; c < fmvt_pkg::Dim; c++) begin
      for (int r = 0; r < fmvt_pkg::Dim; r++) begin
        col[c][r] = mat_q[r * fmvt_pkg::Dim + c];
      end
    end
  end

  for (genvar c = 0; c < fmvt_pkg::Dim; c++) begin : g_lane
    fmvt_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (lane_en),
      .vec_i  (vec),
      .col_i  (col[c]),
      .pair_o (pair[c])
    );
  end

  fmvt_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (out_rdy && pair_valid_q),
    .pair_i (pair),
    .res_o  (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### design/fmvt_checker.sv
// ----------------------------------------------------------------------------
// fmvt_checker: port-level checks for the transform unit
// Watches handshakes and pipeline timing from the top-level ports only.
// ----------------------------------------------------------------------------
`default_nettype none

module fmvt_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire fmvt_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire fmvt_pkg::out_t out_data_o
);

  logic xfm_acc;
  assign xfm_acc = in_valid_i && in_ready_o &&
                   (in_data_i.operation == fmvt_pkg::OpTransform);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed or vanished while stalled");

  // The input can only be blocked when the output register is full and stalled.
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

  // With the output draining, a transform passes the product, pair and output registers to out_valid_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfm_acc ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("transform result missing after three cycles");

  // Right after reset nothing can be waiting at the output.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result word present right after reset");

endmodule

bind fixed_mat4_vector_transform fmvt_checker u_fmvt_checker (.*);

`default_nettype wire
